FILE: hdl/grasp_task_sequencer_core_assert.svh
// Assertion macros for the task sequencer checker.
`ifndef GRASP_TASK_SEQUENCER_CORE_ASSERT_SVH
`define GRASP_TASK_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define GTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define GTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/gts_pkg.sv
`default_nettype none

package gts_pkg;

    typedef logic [3:0] mode_t;
    typedef logic [4:0] event_t;

    typedef struct packed {
        mode_t mode;
        logic  busy;
    } step_res_t;

    localparam mode_t M_READY     = 4'd0;
    localparam mode_t M_STREAM    = 4'd1;
    localparam mode_t M_COLLECT   = 4'd2;
    localparam mode_t M_PROCESS   = 4'd3;
    localparam mode_t M_PICKSPOT  = 4'd4;
    localparam mode_t M_GOTOSPOT  = 4'd5;
    localparam mode_t M_RESURVEY  = 4'd6;
    localparam mode_t M_PICKGRASP = 4'd7;
    localparam mode_t M_GOTOGRASP = 4'd8;
    localparam mode_t M_CLOSEJAW  = 4'd9;
    localparam mode_t M_RETARGET  = 4'd10;
    localparam mode_t M_REPARK    = 4'd11;
    localparam mode_t M_SUCCESS   = 4'd12;
    localparam mode_t M_FAIL      = 4'd13;
    localparam mode_t M_ESTOP     = 4'd14;
    localparam mode_t M_UNUSED    = 4'd15;

    localparam event_t EV_COLLIDED       = 5'd0;
    localparam event_t EV_STOP           = 5'd1;
    localparam event_t EV_FAILURE        = 5'd2;
    localparam event_t EV_START          = 5'd3;
    localparam event_t EV_STREAMING      = 5'd4;
    localparam event_t EV_NO_STREAM      = 5'd5;
    localparam event_t EV_FRAMES_IN      = 5'd6;
    localparam event_t EV_NO_CAND_SPOT   = 5'd7;
    localparam event_t EV_NO_CAND_GRASP  = 5'd8;
    localparam event_t EV_CAND_SPOT      = 5'd9;
    localparam event_t EV_CAND_GRASP     = 5'd10;
    localparam event_t EV_SURVEY_AGAIN   = 5'd11;
    localparam event_t EV_OUT_OF_TIME    = 5'd12;
    localparam event_t EV_SPOT_CHOSEN    = 5'd13;
    localparam event_t EV_SPOT_UNCHANGED = 5'd14;
    localparam event_t EV_NO_SPOT        = 5'd15;
    localparam event_t EV_ARRIVED        = 5'd16;
    localparam event_t EV_PLAN_FOUND     = 5'd17;
    localparam event_t EV_NO_PLAN        = 5'd18;
    localparam event_t EV_REACHED        = 5'd19;
    localparam event_t EV_STALLED        = 5'd20;
    localparam event_t EV_JAW_SETTLED    = 5'd21;
    localparam event_t EV_LOOK_AGAIN     = 5'd22;
    localparam event_t EV_OUT_OF_LOOKS   = 5'd23;
    localparam event_t EV_PARK_AGAIN     = 5'd24;
    localparam event_t EV_OUT_OF_PARKS   = 5'd25;

    function automatic logic mode_busy(input mode_t m);
        return !(m inside {M_READY, M_SUCCESS, M_FAIL, M_ESTOP});
    endfunction

endpackage

`default_nettype wire

FILE: hdl/gts_next_mode.sv
`default_nettype none

module gts_next_mode (
    input  wire gts_pkg::mode_t     cur_mode,
    input  wire gts_pkg::event_t    event_code,
    output gts_pkg::step_res_t      step
);

    logic           busy;
    gts_pkg::mode_t table_mode;
    gts_pkg::mode_t new_mode;

    assign busy = gts_pkg::mode_busy(cur_mode);

    always_comb
    begin
        table_mode = cur_mode;
        case (cur_mode)
            gts_pkg::M_STREAM:
            begin
                if (event_code == gts_pkg::EV_STREAMING)
                    table_mode = gts_pkg::M_COLLECT;
                else if (event_code == gts_pkg::EV_NO_STREAM)
                    table_mode = gts_pkg::M_FAIL;
            end
            gts_pkg::M_COLLECT:
            begin
                if (event_code == gts_pkg::EV_FRAMES_IN)
                    table_mode = gts_pkg::M_PROCESS;
                else if (event_code == gts_pkg::EV_NO_CAND_SPOT)
                    table_mode = gts_pkg::M_RESURVEY;
                else if (event_code == gts_pkg::EV_NO_CAND_GRASP)
                    table_mode = gts_pkg::M_RETARGET;
            end
            gts_pkg::M_PROCESS:
            begin
                if (event_code == gts_pkg::EV_CAND_SPOT)
                    table_mode = gts_pkg::M_PICKSPOT;
                else if (event_code == gts_pkg::EV_CAND_GRASP)
                    table_mode = gts_pkg::M_PICKGRASP;
                else if (event_code == gts_pkg::EV_NO_CAND_SPOT)
                    table_mode = gts_pkg::M_RESURVEY;
                else if (event_code == gts_pkg::EV_NO_CAND_GRASP)
                    table_mode = gts_pkg::M_RETARGET;
            end
            gts_pkg::M_RESURVEY:
            begin
                if (event_code == gts_pkg::EV_SURVEY_AGAIN)
                    table_mode = gts_pkg::M_COLLECT;
                else if (event_code == gts_pkg::EV_OUT_OF_TIME)
                    table_mode = gts_pkg::M_FAIL;
            end
            gts_pkg::M_PICKSPOT:
            begin
                if (event_code == gts_pkg::EV_SPOT_CHOSEN)
                    table_mode = gts_pkg::M_GOTOSPOT;
                else if (event_code == gts_pkg::EV_SPOT_UNCHANGED)
                    table_mode = gts_pkg::M_COLLECT;
                else if (event_code == gts_pkg::EV_NO_SPOT)
                    table_mode = gts_pkg::M_REPARK;
            end
            gts_pkg::M_GOTOSPOT:
            begin
                if (event_code == gts_pkg::EV_ARRIVED)
                    table_mode = gts_pkg::M_COLLECT;
            end
            gts_pkg::M_PICKGRASP:
            begin
                if (event_code == gts_pkg::EV_PLAN_FOUND)
                    table_mode = gts_pkg::M_GOTOGRASP;
                else if (event_code == gts_pkg::EV_NO_PLAN)
                    table_mode = gts_pkg::M_RETARGET;
            end
            gts_pkg::M_GOTOGRASP:
            begin
                if (event_code == gts_pkg::EV_REACHED)
                    table_mode = gts_pkg::M_CLOSEJAW;
                else if (event_code == gts_pkg::EV_STALLED)
                    table_mode = gts_pkg::M_RETARGET;
            end
            gts_pkg::M_CLOSEJAW:
            begin
                if (event_code == gts_pkg::EV_JAW_SETTLED)
                    table_mode = gts_pkg::M_SUCCESS;
            end
            gts_pkg::M_RETARGET:
            begin
                if (event_code == gts_pkg::EV_LOOK_AGAIN)
                    table_mode = gts_pkg::M_COLLECT;
                else if (event_code == gts_pkg::EV_OUT_OF_LOOKS)
                    table_mode = gts_pkg::M_REPARK;
            end
            gts_pkg::M_REPARK:
            begin
                if (event_code == gts_pkg::EV_PARK_AGAIN)
                    table_mode = gts_pkg::M_COLLECT;
                else if (event_code == gts_pkg::EV_OUT_OF_PARKS)
                    table_mode = gts_pkg::M_FAIL;
            end
            default:
            begin
                table_mode = cur_mode;
            end
        endcase
    end

    always_comb
    begin
        case (event_code)
            gts_pkg::EV_COLLIDED,
            gts_pkg::EV_STOP:
                new_mode = busy ? gts_pkg::M_ESTOP : cur_mode;
            gts_pkg::EV_FAILURE:
                new_mode = busy ? gts_pkg::M_FAIL : cur_mode;
            gts_pkg::EV_START:
                new_mode = busy ? cur_mode : gts_pkg::M_STREAM;
            default:
                new_mode = table_mode;
        endcase
    end

    assign step.mode = new_mode;
    assign step.busy = gts_pkg::mode_busy(new_mode);

endmodule

`default_nettype wire

FILE: hdl/grasp_task_sequencer_core.sv
// Task-mode sequencer for a perception-guided pick.
// Input channel: in_valid / in_stall carry one event code word (event_req).
// Output channel: out_valid / out_stall carry one result word per event:
// the new mode and busy_res, high when that mode is a working mode.
// The event register holds an accepted word; its result is written to the
// result register when the event advances, which a stalled output can delay.
// Throughput: one event per cycle while the output does not stall; the only
// feedback is the 4-bit mode register through one small transition lookup.
// An event register and a result register part the two channels, so a new
// event is taken while a finished result still waits to be taken.
// When the receiver stalls, the result holds and one more event is taken
// into the event register; in_stall then rises until the result drains.
// Reset (rst_n low, asynchronous) sets the mode to ready and empties both
// registers; no result is pending after reset.

`default_nettype none

module grasp_task_sequencer_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  wire gts_pkg::event_t event_req,
    output logic                 out_valid,
    input  wire                  out_stall,
    output gts_pkg::mode_t       mode,
    output logic                 busy_res
);

    logic               in_valid_reg;
    logic               in_valid_next;
    gts_pkg::event_t    event_reg;
    gts_pkg::mode_t     cur_mode_reg;
    gts_pkg::mode_t     cur_mode_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    gts_pkg::mode_t     res_mode_reg;
    logic               res_busy_reg;
    logic               advance;
    gts_pkg::step_res_t step;

    gts_next_mode u_next (
        .cur_mode   (cur_mode_reg),
        .event_code (event_reg),
        .step       (step)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_comb
    begin
        in_valid_next  = in_stall ? in_valid_reg : in_valid;
        cur_mode_next  = advance ? step.mode : cur_mode_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            cur_mode_reg  <= gts_pkg::M_READY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            cur_mode_reg  <= cur_mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the event word while stalled
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            event_reg <= event_req;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_mode_reg <= step.mode;
            res_busy_reg <= step.busy;
        end
    end

    assign out_valid = out_valid_reg;
    assign mode      = res_mode_reg;
    assign busy_res  = res_busy_reg;

endmodule

`default_nettype wire

FILE: hdl/gts_checker.sv
`default_nettype none

`include "grasp_task_sequencer_core_assert.svh"

module gts_checker (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  in_valid,
    input wire                  in_stall,
    input wire gts_pkg::event_t event_req,
    input wire                  out_valid,
    input wire                  out_stall,
    input wire gts_pkg::mode_t  mode,
    input wire                  busy_res
);

    logic idle_mode;

    assign idle_mode = (mode == gts_pkg::M_READY) || (mode == gts_pkg::M_SUCCESS) ||
                       (mode == gts_pkg::M_FAIL) || (mode == gts_pkg::M_ESTOP);

    `GTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(mode) && $stable(busy_res), "stalled result word changed")

    `GTS_ASSERT_NOW(a_busy_flag, out_valid, busy_res == !idle_mode,
        "busy_res disagrees with mode")

    `GTS_ASSERT_NOW(a_mode_range, out_valid, mode != gts_pkg::M_UNUSED,
        "unused mode encoding reported")

    `GTS_ASSERT_NOW(a_stall_only_full, in_stall, out_valid && out_stall,
        "input stalled while result register can drain")

    `GTS_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
        in_valid && $stable(event_req), "stalled event word changed")

endmodule

bind grasp_task_sequencer_core gts_checker u_gts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .event_req (event_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .mode      (mode),
    .busy_res  (busy_res)
);

`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none

module testbench;

    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 120;
    localparam gts_pkg::event_t EV_UNDEF_LO = 5'd26;
    localparam gts_pkg::event_t EV_UNDEF_HI = 5'd31;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    gts_pkg::event_t    event_req = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    gts_pkg::mode_t     mode;
    logic               busy_res;

    gts_pkg::step_res_t mode_q[$];
    gts_pkg::mode_t     track_mode = gts_pkg::M_READY;
    int        errors = 0;
    int        idle_cycles = 0;
    int        stall_left = 0;
    int        stall_roll;
    logic      hold_req = 1'b0;
    bit        in_gaps_on = 1'b1;
    bit        out_quiet = 1'b0;

    grasp_task_sequencer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .event_req (event_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mode      (mode),
        .busy_res  (busy_res)
    );

    always #1 clk = ~clk;

    function automatic logic is_working(input gts_pkg::mode_t m);
        case (m)
            gts_pkg::M_READY, gts_pkg::M_SUCCESS, gts_pkg::M_FAIL, gts_pkg::M_ESTOP:
                return 1'b0;
            default: return 1'b1;
        endcase
    endfunction

    function automatic gts_pkg::mode_t next_mode(input gts_pkg::mode_t m,
                                                 input gts_pkg::event_t ev);
        logic working;
        working = is_working(m);
        if (ev == gts_pkg::EV_COLLIDED || ev == gts_pkg::EV_STOP)
            return working ? gts_pkg::M_ESTOP : m;
        if (ev == gts_pkg::EV_FAILURE)
            return working ? gts_pkg::M_FAIL : m;
        if (ev == gts_pkg::EV_START)
            return working ? m : gts_pkg::M_STREAM;
        case (m)
            gts_pkg::M_STREAM:
            begin
                if (ev == gts_pkg::EV_STREAMING) return gts_pkg::M_COLLECT;
                if (ev == gts_pkg::EV_NO_STREAM) return gts_pkg::M_FAIL;
            end
            gts_pkg::M_COLLECT:
            begin
                if (ev == gts_pkg::EV_FRAMES_IN) return gts_pkg::M_PROCESS;
                if (ev == gts_pkg::EV_NO_CAND_SPOT) return gts_pkg::M_RESURVEY;
                if (ev == gts_pkg::EV_NO_CAND_GRASP) return gts_pkg::M_RETARGET;
            end
            gts_pkg::M_PROCESS:
            begin
                if (ev == gts_pkg::EV_CAND_SPOT) return gts_pkg::M_PICKSPOT;
                if (ev == gts_pkg::EV_CAND_GRASP) return gts_pkg::M_PICKGRASP;
                if (ev == gts_pkg::EV_NO_CAND_SPOT) return gts_pkg::M_RESURVEY;
                if (ev == gts_pkg::EV_NO_CAND_GRASP) return gts_pkg::M_RETARGET;
            end
            gts_pkg::M_RESURVEY:
            begin
                if (ev == gts_pkg::EV_SURVEY_AGAIN) return gts_pkg::M_COLLECT;
                if (ev == gts_pkg::EV_OUT_OF_TIME) return gts_pkg::M_FAIL;
            end
            gts_pkg::M_PICKSPOT:
            begin
                if (ev == gts_pkg::EV_SPOT_CHOSEN) return gts_pkg::M_GOTOSPOT;
                if (ev == gts_pkg::EV_SPOT_UNCHANGED) return gts_pkg::M_COLLECT;
                if (ev == gts_pkg::EV_NO_SPOT) return gts_pkg::M_REPARK;
            end
            gts_pkg::M_GOTOSPOT:
            begin
                if (ev == gts_pkg::EV_ARRIVED) return gts_pkg::M_COLLECT;
            end
            gts_pkg::M_PICKGRASP:
            begin
                if (ev == gts_pkg::EV_PLAN_FOUND) return gts_pkg::M_GOTOGRASP;
                if (ev == gts_pkg::EV_NO_PLAN) return gts_pkg::M_RETARGET;
            end
            gts_pkg::M_GOTOGRASP:
            begin
                if (ev == gts_pkg::EV_REACHED) return gts_pkg::M_CLOSEJAW;
                if (ev == gts_pkg::EV_STALLED) return gts_pkg::M_RETARGET;
            end
            gts_pkg::M_CLOSEJAW:
            begin
                if (ev == gts_pkg::EV_JAW_SETTLED) return gts_pkg::M_SUCCESS;
            end
            gts_pkg::M_RETARGET:
            begin
                if (ev == gts_pkg::EV_LOOK_AGAIN) return gts_pkg::M_COLLECT;
                if (ev == gts_pkg::EV_OUT_OF_LOOKS) return gts_pkg::M_REPARK;
            end
            gts_pkg::M_REPARK:
            begin
                if (ev == gts_pkg::EV_PARK_AGAIN) return gts_pkg::M_COLLECT;
                if (ev == gts_pkg::EV_OUT_OF_PARKS) return gts_pkg::M_FAIL;
            end
            default: ;
        endcase
        return m;
    endfunction

    function automatic gts_pkg::event_t pick_event(input gts_pkg::mode_t m);
        gts_pkg::event_t ev;
        int              r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return gts_pkg::event_t'($urandom_range(0, 31));
        if (r < 14)
            return gts_pkg::event_t'($urandom_range(gts_pkg::EV_COLLIDED,
                                                    gts_pkg::EV_FAILURE));
        ev = gts_pkg::EV_START;
        for (int tries = 0; tries < 40; tries++)
        begin
            ev = gts_pkg::event_t'($urandom_range(gts_pkg::EV_START,
                                                  gts_pkg::EV_OUT_OF_PARKS));
            if (next_mode(m, ev) != m)
                return ev;
        end
        return ev;
    endfunction

    function automatic void report_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    task automatic send_word(input gts_pkg::event_t ev);
        int r;
        int gap;
        in_valid <= 1'b1;
        event_req <= ev;
        do
            @(posedge clk);
        while (in_stall);
        track_mode = next_mode(track_mode, ev);
        mode_q.push_back('{mode: track_mode, busy: is_working(track_mode)});
        gap = 0;
        if (in_gaps_on)
        begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                gap = $urandom_range(8, 40);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic pause_until_drained;
        in_valid <= 1'b0;
        @(posedge clk);
        while (mode_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_word(pick_event(track_mode));
    endtask

    task automatic test_directed;
        gts_pkg::event_t seq[$];
        seq = '{EV_UNDEF_HI, gts_pkg::EV_COLLIDED, gts_pkg::EV_FAILURE,
                gts_pkg::EV_STREAMING, gts_pkg::EV_START, gts_pkg::EV_START,
                gts_pkg::EV_STREAMING, gts_pkg::EV_FRAMES_IN, gts_pkg::EV_CAND_GRASP,
                gts_pkg::EV_PLAN_FOUND, gts_pkg::EV_REACHED, gts_pkg::EV_JAW_SETTLED,
                gts_pkg::EV_STOP, gts_pkg::EV_START, gts_pkg::EV_NO_STREAM,
                gts_pkg::EV_START, gts_pkg::EV_STREAMING, gts_pkg::EV_NO_CAND_SPOT,
                gts_pkg::EV_OUT_OF_TIME, gts_pkg::EV_START, gts_pkg::EV_STREAMING,
                gts_pkg::EV_NO_CAND_GRASP, gts_pkg::EV_OUT_OF_LOOKS,
                gts_pkg::EV_OUT_OF_PARKS, gts_pkg::EV_START, EV_UNDEF_LO,
                gts_pkg::EV_COLLIDED};
        foreach (seq[i])
            send_word(seq[i]);
        pause_until_drained();
    endtask

    task automatic test_random_gapped;
        in_gaps_on = 1'b1;
        run_random(700);
        pause_until_drained();
    endtask

    task automatic test_back_to_back;
        in_gaps_on = 1'b0;
        out_quiet = 1'b1;
        run_random(300);
        out_quiet = 1'b0;
        pause_until_drained();
    endtask

    task automatic test_output_hold;
        in_gaps_on = 1'b0;
        hold_req <= 1'b1;
        run_random(40);
        in_gaps_on = 1'b1;
        pause_until_drained();
    endtask

    task automatic test_random_mixed;
        repeat (8)
        begin
            in_gaps_on = 1'($urandom_range(0, 1));
            run_random(100);
        end
        in_gaps_on = 1'b1;
        pause_until_drained();
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req <= 1'b0;
            stall_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (out_quiet)
            out_stall <= 1'b0;
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 70)
                out_stall <= 1'b0;
            else
            begin
                stall_left = (stall_roll < 96) ? $urandom_range(0, 2) : $urandom_range(10, 30);
                out_stall <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (mode_q.size() == 0)
                report_error($sformatf("unexpected word: mode %0d busy %0b", mode, busy_res));
            else
            begin
                if (mode !== mode_q[0].mode || busy_res !== mode_q[0].busy)
                    report_error($sformatf("mismatch: mode exp %0d got %0d, busy exp %0b got %0b",
                                           mode_q[0].mode, mode, mode_q[0].busy, busy_res));
                void'(mode_q.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_gapped();
        test_back_to_back();
        test_output_hold();
        test_random_mixed();
        in_valid <= 1'b0;
        while (mode_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (mode_q.size() != 0)
            report_error($sformatf("%0d words never arrived", mode_q.size()));
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
